// ===== design/sffl_pkg.sv =====
// Package for the SYN flood flow limiter: table geometry, register indexes,
// entry layout and the lookup3 three-word hash split into two halves. No dependencies.
package sffl_pkg;

  localparam int BUCKETS = 256;
  localparam int WAYS = 4;
  localparam int SET_W = $clog2(BUCKETS);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_BLOCK = 2'd2;

  typedef struct packed {
    logic        valid;
    logic        blocked;
    logic [15:0] iface;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] count;
    logic [31:0] stamp;
  } entry_t;

  typedef entry_t [WAYS-1:0] set_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } mix_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  // First half of the final mix: seeding and three rounds.
  function automatic mix_t mix_front(input logic [31:0] a0, input logic [31:0] b0,
                                     input logic [31:0] c0);
    mix_t m;
    m.a = a0 + 32'hdeadbeef + 32'd12;
    m.b = b0 + 32'hdeadbeef + 32'd12;
    m.c = c0 + 32'hdeadbeef + 32'd12;
    m.c = (m.c ^ m.b) - rotl(m.b, 14);
    m.a = (m.a ^ m.c) - rotl(m.c, 11);
    m.b = (m.b ^ m.a) - rotl(m.a, 25);
    return m;
  endfunction

  // Second half of the final mix: the remaining four rounds.
  function automatic logic [31:0] mix_back(input mix_t m0);
    mix_t m;
    m = m0;
    m.c = (m.c ^ m.b) - rotl(m.b, 16);
    m.a = (m.a ^ m.c) - rotl(m.c, 4);
    m.b = (m.b ^ m.a) - rotl(m.a, 14);
    m.c = (m.c ^ m.b) - rotl(m.b, 24);
    return m.c;
  endfunction

  function automatic logic later(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return d[31];
  endfunction

  function automatic logic [31:0] inc_sat(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ===== design/sffl_table.sv =====
// Flow table of the SYN flood limiter: one row per bucket holding all ways, written
// one way at a time, with a registered row read and a clearing pass over all BUCKETS rows
// after reset. Depends on sffl_pkg.
module sffl_table (
  input  logic                  clk,
  input  logic                  rst,
  output logic                  busy,
  input  logic                  rd_en,
  input  logic [sffl_pkg::SET_W-1:0] rd_addr,
  output sffl_pkg::set_t        rd_data,
  input  logic                  wr_en,
  input  logic [sffl_pkg::SET_W-1:0] wr_addr,
  input  logic [sffl_pkg::WAY_W-1:0] wr_way,
  input  sffl_pkg::entry_t      wr_data
);
  import sffl_pkg::*;

  set_t mem [BUCKETS];
  logic clearing;
  logic [SET_W-1:0] clr_addr;

  assign busy = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + SET_W'(1);
      if (clr_addr == SET_W'(BUCKETS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr][wr_way] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/syn_flood_flow_limiter_core.sv =====
// Per-flow SYN flood limiter. After reset the core clears the flow table and holds
// s_tready low meanwhile. A request goes through these steps: the first half of the
// hash is registered at acceptance, the second half addresses the row read of the flow
// table, and tag compare and write-back follow; a new request is taken only in idle.
// A non-SYN or disabled-mode request takes the same steps. A result that waits on
// m_tready holds the core in its last step until the output register frees.
module syn_flood_flow_limiter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // is_tcp[0], syn_flag[1], iface[17:2], src_addr[49:18], dst_addr[81:50],
  // now[113:82], zero pad
  input  logic [119:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // verdict[0], attack_found[1], untracked[2], zero pad
  output logic [7:0]  m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sffl_pkg::*;

  logic [1:0]  mode;
  logic [15:0] syn_threshold;
  logic [31:0] interval_ticks;
  logic [31:0] timeout_ticks;

  state_t state, state_next;
  logic        is_syn;
  logic [15:0] iface;
  logic [31:0] src, dst, now;
  mix_t        hmix;
  logic [SET_W-1:0] set_idx;
  set_t        rows;
  logic        tbl_busy;
  logic        wr_en;
  logic [WAY_W-1:0] wr_way;
  entry_t      wr_data;
  logic [2:0]  res;
  logic        out_full;
  logic        out_load;

  assign cfg_ready = 1'b1;
  assign s_tready = (state == ST_IDLE) && !tbl_busy;
  assign m_tvalid = out_full;
  assign out_load = (state == ST_UPDATE) && (!out_full || m_tready);
  assign set_idx = SET_W'(mix_back(hmix));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_BLOCK;
      syn_threshold <= 16'd100;
      interval_ticks <= 32'd1000;
      timeout_ticks <= 32'd10000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE: mode <= cfg_data[1:0];
        REG_THRESHOLD: syn_threshold <= cfg_data[15:0];
        REG_INTERVAL: interval_ticks <= cfg_data;
        REG_TIMEOUT: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      is_syn <= s_tdata[0] && s_tdata[1] && (mode != MODE_OFF);
      iface <= s_tdata[17:2];
      src <= s_tdata[49:18];
      dst <= s_tdata[81:50];
      now <= s_tdata[113:82];
      hmix <= mix_front({16'd0, s_tdata[17:2]}, s_tdata[49:18], s_tdata[81:50]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid && s_tready) state_next = ST_READ;
      ST_READ: state_next = ST_UPDATE;
      ST_UPDATE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  sffl_table u_table (
    .clk(clk), .rst(rst), .busy(tbl_busy),
    .rd_en(state == ST_READ), .rd_addr(set_idx), .rd_data(rows),
    .wr_en(wr_en), .wr_addr(set_idx), .wr_way(wr_way), .wr_data(wr_data)
  );

  always_comb begin
    logic hit, fr;
    logic [WAY_W-1:0] hw, fw;
    entry_t e;
    logic [31:0] c1;
    hit = 1'b0; fr = 1'b0; hw = '0; fw = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rows[w].valid && rows[w].iface == iface && rows[w].src == src &&
          rows[w].dst == dst) begin
        hit = 1'b1; hw = WAY_W'(w);
      end
      if (!rows[w].valid) begin
        fr = 1'b1; fw = WAY_W'(w);
      end
    end
    e = rows[hw];
    if (!hit) begin
      e = '0;
      e.iface = iface; e.src = src; e.dst = dst;
    end
    e.valid = 1'b1;
    wr_way = hit ? hw : fw;
    res = 3'b000;
    wr_en = 1'b0;
    c1 = inc_sat(e.count);
    if (!is_syn) begin
      res = 3'b000;
    end else if (!hit && !fr) begin
      res = 3'b100;
    end else begin
      wr_en = out_load;
      if (e.blocked ? later(now, e.stamp + timeout_ticks)
                    : later(now, e.stamp + interval_ticks)) begin
        e.stamp = now; e.count = 32'd1; e.blocked = 1'b0;
      end else if (!e.blocked && c1 < {16'd0, syn_threshold}) begin
        e.count = c1;
      end else begin
        res[1] = !e.blocked;
        if (!e.blocked) e.count = c1;
        e.blocked = 1'b1;
        e.stamp = now;
        e.count = inc_sat(e.count);
        res[0] = (mode == MODE_BLOCK);
      end
    end
    wr_data = e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_load) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'd0, res};
    end
  end

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_full && !m_tready |=> out_full && $stable(m_tdata)) else $error("result overwritten");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_tready) else $error("accepted while busy");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> state == ST_UPDATE) else $error("bad sequence");
  a_write_only_update: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == ST_UPDATE && is_syn) else $error("stray write");

endmodule

// ===== test/syn_flood_flow_limiter_core_tb.sv =====
// Self-checking testbench for syn_flood_flow_limiter_core: drives packet requests
// and register writes, predicts every verdict with a flow table model of its own.
// Depends on sffl_pkg and the core RTL.
module syn_flood_flow_limiter_core_tb;
  import sffl_pkg::*;

  localparam int SLOTS = BUCKETS * WAYS;

  typedef struct {
    logic [15:0] iface;
    logic [31:0] src;
    logic [31:0] dst;
  } flow_key_t;

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] thr;
    logic [31:0] intv;
    logic [31:0] tmo;
    int          step;
  } phase_cfg_t;

  class flow_scoreboard;
    logic [1:0]  mode;
    logic [15:0] thr;
    logic [31:0] intv;
    logic [31:0] tmo;
    bit          used [SLOTS];
    logic [15:0] key_if [SLOTS];
    logic [31:0] key_src [SLOTS];
    logic [31:0] key_dst [SLOTS];
    logic [31:0] cnt [SLOTS];
    logic [31:0] stamp [SLOTS];
    bit          blk [SLOTS];
    logic [2:0]  verdicts [$];
    int          errors;

    function new();
      mode = MODE_BLOCK;
      thr = 16'd100;
      intv = 32'd1000;
      tmo = 32'd10000;
      errors = 0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function int bucket_of(logic [15:0] ifc, logic [31:0] sa, logic [31:0] da);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      a = {16'd0, ifc} + 32'hdeadbeef + 32'd12;
      b = sa + 32'hdeadbeef + 32'd12;
      c = da + 32'hdeadbeef + 32'd12;
      c = c ^ b; c = c - rol(b, 14);
      a = a ^ c; a = a - rol(c, 11);
      b = b ^ a; b = b - rol(a, 25);
      c = c ^ b; c = c - rol(b, 16);
      a = a ^ c; a = a - rol(c, 4);
      b = b ^ a; b = b - rol(a, 14);
      c = c ^ b; c = c - rol(b, 24);
      return int'(c % BUCKETS);
    endfunction

    function bit expired(logic [31:0] t, logic [31:0] limit);
      logic [31:0] d;
      d = limit - t;
      return d[31];
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_MODE: mode = v[1:0];
        REG_THRESHOLD: thr = v[15:0];
        REG_INTERVAL: intv = v;
        default: tmo = v;
      endcase
    endfunction

    function void note_request(logic [119:0] d);
      logic [15:0] ifc;
      logic [31:0] sa;
      logic [31:0] da;
      logic [31:0] t;
      bit verdict;
      bit attack;
      bit untracked;
      bit hit;
      bit restart;
      bit blocking;
      int s;
      int base;
      ifc = d[17:2];
      sa = d[49:18];
      da = d[81:50];
      t = d[113:82];
      verdict = 0; attack = 0; untracked = 0; hit = 0; restart = 0; blocking = 0; s = 0;
      if (d[0] && d[1] && mode != MODE_OFF) begin
        base = bucket_of(ifc, sa, da) * WAYS;
        for (int w = 0; w < WAYS; w++)
          if (!hit && used[base+w] && key_if[base+w] == ifc && key_src[base+w] == sa &&
              key_dst[base+w] == da) begin
            s = base + w;
            hit = 1;
          end
        for (int w = 0; w < WAYS; w++)
          if (!hit && !used[base+w]) begin
            s = base + w;
            hit = 1;
            used[s] = 1;
            key_if[s] = ifc;
            key_src[s] = sa;
            key_dst[s] = da;
            cnt[s] = 0;
            stamp[s] = 0;
            blk[s] = 0;
          end
        if (!hit) begin
          untracked = 1;
        end else if (blk[s]) begin
          if (expired(t, stamp[s] + tmo)) restart = 1;
          else blocking = 1;
        end else if (expired(t, stamp[s] + intv)) begin
          restart = 1;
        end else begin
          cnt[s] = bump(cnt[s]);
          if (cnt[s] >= {16'd0, thr}) begin
            blk[s] = 1;
            attack = 1;
            blocking = 1;
          end
        end
        if (restart) begin
          stamp[s] = t;
          cnt[s] = 1;
          blk[s] = 0;
        end
        if (blocking) begin
          stamp[s] = t;
          cnt[s] = bump(cnt[s]);
          verdict = (mode == MODE_BLOCK);
        end
      end
      verdicts.push_back({untracked, attack, verdict});
    endfunction

    function void check_result(logic [7:0] r);
      logic [2:0] e;
      if (verdicts.size() == 0) begin
        $error("result with no request pending: %h", r);
        errors++;
        return;
      end
      e = verdicts.pop_front();
      if (r[0] !== e[0]) begin
        $error("verdict expected %0d got %0d", e[0], r[0]);
        errors++;
      end
      if (r[1] !== e[1]) begin
        $error("attack_found expected %0d got %0d", e[1], r[1]);
        errors++;
      end
      if (r[2] !== e[2]) begin
        $error("untracked expected %0d got %0d", e[2], r[2]);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [119:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [7:0]   m_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;

  flow_scoreboard sb;
  int send_idle;
  int recv_idle;
  int items_sent;
  int idle_cycles;
  bit hold_req;
  logic [31:0] tick;
  flow_key_t pool [$];
  phase_cfg_t phases [9];

  syn_flood_flow_limiter_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    m_tready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        m_tready <= 0;
        repeat (300) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
      @(posedge clk);
    end
  end

  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  always @(negedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("syn_flood_flow_limiter_core test failed");
        $finish;
      end
    end
  end

  function automatic logic [119:0] pack(bit tcp, bit syn, flow_key_t k, logic [31:0] t);
    return {6'd0, t, k.dst, k.src, k.iface, syn, tcp};
  endfunction

  task automatic send_packet(logic [119:0] d);
    logic acc;
    if (items_sent < 580) begin
      send_idle = 7; recv_idle = 73;
    end else if (items_sent < 1160) begin
      send_idle = 73; recv_idle = 7;
    end else begin
      send_idle = 0; recv_idle = 0;
    end
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= d;
    do begin
      @(negedge clk);
      acc = s_tready;
      @(posedge clk);
    end while (!acc);
    sb.note_request(d);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.verdicts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    logic acc;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_config(phase_cfg_t c);
    write_reg(REG_MODE, {30'd0, c.mode});
    write_reg(REG_THRESHOLD, {16'd0, c.thr});
    write_reg(REG_INTERVAL, c.intv);
    write_reg(REG_TIMEOUT, c.tmo);
    cfg_valid <= 0;
  endtask

  task automatic random_packet(int step);
    flow_key_t k;
    if ($urandom_range(99) < 80) begin
      k = pool[$urandom_range(pool.size() - 1)];
      send_packet(pack(1'b1, $urandom_range(9) != 0, k, tick));
      if ($urandom_range(99) == 0) tick += $urandom;
      else tick += $urandom_range(0, step);
    end else begin
      k.iface = 16'($urandom);
      k.src = $urandom;
      k.dst = $urandom;
      send_packet(pack(1'($urandom_range(1)), 1'($urandom_range(1)), k, $urandom));
    end
  endtask

  initial begin
    flow_key_t k;
    flow_key_t clash [$];
    int target;
    sb = new();
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    cfg_valid = 0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    hold_req = 0;
    items_sent = 0;
    idle_cycles = 0;
    send_idle = 7;
    recv_idle = 73;
    tick = 32'hFFFF_FF00;
    phases[0] = '{2'd2, 16'd3, 32'd50, 32'd200, 20};
    phases[1] = '{2'd1, 16'd5, 32'd100, 32'd400, 40};
    phases[2] = '{2'd2, 16'd1, 32'd0, 32'd0, 2};
    phases[3] = '{2'd3, 16'd2, 32'd30, 32'd100, 15};
    phases[4] = '{2'd0, 16'd4, 32'd50, 32'd50, 20};
    phases[5] = '{2'd2, 16'd0, 32'd20, 32'd60, 10};
    phases[6] = '{2'd2, 16'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 50};
    phases[7] = '{2'd2, 16'd4, 32'd40, 32'hFFFF_FFFF, 20};
    phases[8] = '{2'd2, 16'd3, 32'd25, 32'd80, 12};

    for (int i = 0; i < 10; i++) begin
      k.iface = 16'($urandom);
      k.src = $urandom;
      k.dst = $urandom;
      pool.push_back(k);
    end
    k.iface = 16'($urandom);
    k.src = $urandom;
    target = sb.bucket_of(k.iface, k.src, 32'd0);
    k.dst = 0;
    clash.push_back(k);
    while (clash.size() < 6) begin
      k.dst = $urandom;
      if (sb.bucket_of(k.iface, k.src, k.dst) == target) clash.push_back(k);
    end
    foreach (clash[i]) pool.push_back(clash[i]);

    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    k = '{16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send_packet(pack(1'b0, 1'b1, k, 32'hFFFF_FFFF));
    send_packet(pack(1'b1, 1'b0, k, 32'hFFFF_FFFF));
    send_packet(pack(1'b1, 1'b1, k, 32'hFFFF_FFFF));
    send_packet(pack(1'b1, 1'b1, k, 32'h0));
    k = '{16'h0, 32'h0, 32'h0};
    send_packet(pack(1'b0, 1'b0, k, 32'h0));
    send_packet(pack(1'b1, 1'b1, k, 32'h0));
    foreach (clash[i]) send_packet(pack(1'b1, 1'b1, clash[i], 32'd5));
    send_packet(pack(1'b1, 1'b1, clash[0], 32'd6));
    send_packet(pack(1'b1, 1'b1, clash[5], 32'd7));

    foreach (phases[p]) begin
      drain();
      apply_config(phases[p]);
      for (int i = 0; i < 190; i++) begin
        if (p == 3 && i == 40) hold_req = 1;
        random_packet(phases[p].step);
      end
    end
    drain();

    if (sb.errors == 0 && sb.verdicts.size() == 0)
      $display("syn_flood_flow_limiter_core test passed");
    else
      $display("syn_flood_flow_limiter_core test failed");
    $finish;
  end

endmodule
